@@ sv/rth_pkg.sv @@
package rth_pkg;

    // channel and hue widths
    localparam int CHANNEL_BITS = 8;
    localparam int HUE_BITS     = 16;

    // remainder width for the hue divider, holds six times the range
    localparam int HREM_BITS = CHANNEL_BITS + 3;

    // one quotient bit per stage, enough stages for the longer quotient
    localparam int DIV_STAGES = (HUE_BITS > CHANNEL_BITS) ? HUE_BITS : CHANNEL_BITS;

    // stream widths, packed fields filled up to whole bytes
    localparam int IN_FIELD_BITS  = 3 * CHANNEL_BITS;
    localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = HUE_BITS + 2 * CHANNEL_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

    // hue sector offsets in sixths of a turn
    localparam logic [2:0] OFS_RED   = 3'd0;
    localparam logic [2:0] OFS_WRAP  = 3'd6;
    localparam logic [2:0] OFS_GREEN = 3'd2;
    localparam logic [2:0] OFS_BLUE  = 3'd4;

    // first stage: extremes, range and sector
    typedef struct packed {
        logic [CHANNEL_BITS-1:0] mx;
        logic [CHANNEL_BITS-1:0] d;
        logic signed [CHANNEL_BITS:0] diff;
        logic [2:0]              offset;
        logic                    zero;
    } prep_t;

    // divider stage: partial remainders and quotients of both divisions
    typedef struct packed {
        logic [HREM_BITS-1:0]    hrem;
        logic [HUE_BITS-1:0]     hq;
        logic [HREM_BITS-1:0]    dv6;
        logic [CHANNEL_BITS-1:0] srem;
        logic [CHANNEL_BITS-1:0] plow;
        logic [CHANNEL_BITS-1:0] sq;
        logic [CHANNEL_BITS-1:0] mx;
        logic                    zero;
    } div_t;

endpackage

@@ sv/rgb_to_hsv.sv @@
// RGB to HSV pixel converter. Takes one pixel per clock and returns hue,
// saturation and brightness (the largest channel) for each pixel in order.
// One stage finds max, min and the hue sector, one forms the dividends and
// divisors, and the rest are a restoring divider that settles one quotient bit
// of the hue and one of the saturation in each stage until that quotient is
// complete. A pixel can enter every cycle; a stalled output holds the pipeline
// and bubbles are squeezed out.
// Gray and black pixels give hue and saturation of zero.
module rgb_to_hsv (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // red, green, blue
    input  logic [rth_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // hue, saturation, brightness
    output logic [rth_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata
);
    import rth_pkg::*;

    localparam int C = CHANNEL_BITS;
    localparam int H = HUE_BITS;
    localparam int W = HREM_BITS;
    localparam int NS = DIV_STAGES;

    // one restoring division step for each quotient
    function automatic div_t div_step(input div_t s, input logic do_h, input logic do_s);
        div_t         r;
        logic [W:0]   sh_h;
        logic [C:0]   sh_s;
        r    = s;
        sh_h = {s.hrem, 1'b0};
        sh_s = {s.srem, s.plow[C-1]};
        if (do_h)
        begin
            if (sh_h >= {1'b0, s.dv6})
            begin
                r.hrem = W'(sh_h - {1'b0, s.dv6});
                r.hq   = {s.hq[H-2:0], 1'b1};
            end
            else
            begin
                r.hrem = sh_h[W-1:0];
                r.hq   = {s.hq[H-2:0], 1'b0};
            end
        end
        if (do_s)
        begin
            r.plow = {s.plow[C-2:0], 1'b0};
            if (sh_s >= {1'b0, s.mx})
            begin
                r.srem = C'(sh_s - {1'b0, s.mx});
                r.sq   = {s.sq[C-2:0], 1'b1};
            end
            else
            begin
                r.srem = sh_s[C-1:0];
                r.sq   = {s.sq[C-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    logic [C-1:0]  red;
    logic [C-1:0]  green;
    logic [C-1:0]  blue;
    prep_t         prep_next;
    prep_t         prep_reg;
    logic          prep_v_reg;
    logic          prep_ld;
    div_t          st_next [0:NS];
    div_t          st_reg  [0:NS];
    logic [NS:0]   v_reg;
    logic [NS:0]   ld;
    logic [C-1:0]  mx;
    logic [C-1:0]  mn;
    logic [W-1:0]  prod;
    logic signed [W:0] num_s;
    logic [2*C-1:0] p;
    logic [H-1:0]  hue_out;
    logic [C-1:0]  sat_out;

    assign red   = s_axis_tdata[C-1:0];
    assign green = s_axis_tdata[2*C-1:C];
    assign blue  = s_axis_tdata[3*C-1:2*C];

    // stage load enables, a stage takes data when empty or when it moves on
    always_comb
    begin
        ld[NS] = !v_reg[NS] || m_axis_tready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            ld[k] = !v_reg[k] || ld[k+1];
        end
        prep_ld = !prep_v_reg || ld[0];
    end

    assign s_axis_tready = prep_ld;

    // extremes, range, hue sector and signed channel difference
    always_comb
    begin
        mx = (red > green) ? red : green;
        if (blue > mx)
        begin
            mx = blue;
        end
        mn = (red < green) ? red : green;
        if (blue < mn)
        begin
            mn = blue;
        end
        prep_next.mx   = mx;
        prep_next.d    = mx - mn;
        prep_next.zero = (mx == mn);
        if (red > green && red > blue)
        begin
            prep_next.offset = (green < blue) ? OFS_WRAP : OFS_RED;
            prep_next.diff   = $signed({1'b0, green}) - $signed({1'b0, blue});
        end
        else if (green > blue)
        begin
            prep_next.offset = OFS_GREEN;
            prep_next.diff   = $signed({1'b0, blue}) - $signed({1'b0, red});
        end
        else
        begin
            prep_next.offset = OFS_BLUE;
            prep_next.diff   = $signed({1'b0, red}) - $signed({1'b0, green});
        end
    end

    // dividends and divisors for both divisions
    always_comb
    begin
        prod  = W'(prep_reg.offset) * W'(prep_reg.d);
        num_s = $signed({1'b0, prod})
              + $signed({{(W-C){prep_reg.diff[C]}}, prep_reg.diff});
        p     = {prep_reg.d, {C{1'b0}}} - {{C{1'b0}}, prep_reg.d};
        st_next[0].hrem = num_s[W-1:0];
        st_next[0].hq   = '0;
        st_next[0].dv6  = W'({prep_reg.d, 2'b00}) + W'({prep_reg.d, 1'b0});
        st_next[0].srem = p[2*C-1:C];
        st_next[0].plow = p[C-1:0];
        st_next[0].sq   = '0;
        st_next[0].mx   = prep_reg.mx;
        st_next[0].zero = prep_reg.zero;
        for (int k = 1; k <= NS; k++)
        begin
            st_next[k] = div_step(st_reg[k-1], (k - 1) < H, (k - 1) < C);
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_v_reg <= 1'b0;
            v_reg      <= '0;
        end
        else
        begin
            if (prep_ld)
            begin
                prep_v_reg <= s_axis_tvalid;
            end
            if (ld[0])
            begin
                v_reg[0] <= prep_v_reg;
            end
            for (int k = 1; k <= NS; k++)
            begin
                if (ld[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (prep_ld)
        begin
            prep_reg <= prep_next;
        end
        for (int k = 0; k <= NS; k++)
        begin
            if (ld[k])
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    // gray and black pixels give zero hue and saturation
    assign hue_out = st_reg[NS].zero ? '0 : st_reg[NS].hq;
    assign sat_out = st_reg[NS].zero ? '0 : st_reg[NS].sq;

    assign m_axis_tvalid = v_reg[NS];
    assign m_axis_tdata  = OUT_TDATA_BITS'({st_reg[NS].mx, sat_out, hue_out});

endmodule

@@ tb/rgb_to_hsv_checker.sv @@
module rgb_to_hsv_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    // red, green, blue
    input  logic [rth_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // hue, saturation, brightness
    input  logic [rth_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
    output int                                 mismatches,
    output int                                 awaiting
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = rth_pkg::CHANNEL_BITS;
    localparam int HB = rth_pkg::HUE_BITS;

    // full scale of a channel and the number of sectors in a turn
    localparam logic [31:0] CH_FULL     = (32'd1 << CB) - 32'd1;
    localparam logic [31:0] TURN_SIXTHS = 32'(rth_pkg::OFS_WRAP);

    typedef struct packed {
        logic [HB-1:0] hue;
        logic [CB-1:0] sat;
        logic [CB-1:0] val;
    } hsv_t;

    hsv_t hsv_expected_q[$];
    hsv_t want;
    hsv_t got;

    // hue, saturation and value of one pixel
    function automatic hsv_t convert_pixel(input logic [CB-1:0] r, input logic [CB-1:0] g,
                                           input logic [CB-1:0] b);
        logic [CB-1:0] mx;
        logic [CB-1:0] mn;
        logic [CB-1:0] rng;
        logic [31:0]   pos;
        logic [31:0]   hq;
        hsv_t          res;
        mx = (r > g) ? r : g;
        if (b > mx) mx = b;
        mn = (r < g) ? r : g;
        if (b < mn) mn = b;
        rng = mx - mn;
        res.val = mx;
        if (mx == '0)
            res.sat = '0;
        else
            res.sat = CB'((32'(rng) * CH_FULL) / 32'(mx));
        if (rng == '0)
        begin
            hq = '0;
        end
        else
        begin
            // red sector only when red is strictly largest
            if (r > g && r > b)
                pos = ((g < b) ? 32'(rth_pkg::OFS_WRAP) : 32'(rth_pkg::OFS_RED)) * 32'(rng)
                      + 32'(g) - 32'(b);
            else if (g > b)
                pos = 32'(rth_pkg::OFS_GREEN) * 32'(rng) + 32'(b) - 32'(r);
            else
                pos = 32'(rth_pkg::OFS_BLUE) * 32'(rng) + 32'(r) - 32'(g);
            hq = (pos << HB) / (TURN_SIXTHS * 32'(rng));
        end
        res.hue = hq[HB-1:0];
        return res;
    endfunction

    initial
    begin
        mismatches = 0;
        awaiting   = 0;
    end

    // predict on each input transfer, compare on each output transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                hsv_expected_q.push_back(convert_pixel(s_axis_tdata[CB-1:0],
                                                       s_axis_tdata[2*CB-1:CB],
                                                       s_axis_tdata[3*CB-1:2*CB]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.hue = m_axis_tdata[HB-1:0];
                got.sat = m_axis_tdata[HB+CB-1:HB];
                got.val = m_axis_tdata[HB+2*CB-1:HB+CB];
                if (hsv_expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: hue %0d sat %0d val %0d",
                                 got.hue, got.sat, got.val);
                end
                else
                begin
                    want = hsv_expected_q.pop_front();
                    if (got.hue !== want.hue || got.sat !== want.sat || got.val !== want.val)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display(
                                "mismatch: expected hue/sat/val %0d/%0d/%0d, got %0d/%0d/%0d",
                                want.hue, want.sat, want.val, got.hue, got.sat, got.val);
                    end
                end
            end
            awaiting = hsv_expected_q.size();
        end
    end

endmodule

@@ tb/rgb_to_hsv_tb.sv @@
module rgb_to_hsv_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB           = rth_pkg::CHANNEL_BITS;
    localparam int LATENCY      = rth_pkg::DIV_STAGES + 2;
    localparam int DRAIN_CYCLES = 2 * LATENCY + 8;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 1430;
    localparam int QUIET_TAIL   = 200;
    localparam int HOLD_AT      = 500;
    localparam int HOLD_CYCLES  = 300;

    logic                               clk = 1'b0;
    logic                               rst_n;
    logic                               s_axis_tvalid;
    logic                               s_axis_tready;
    logic [rth_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready;
    logic [rth_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata;

    int mismatches;
    int awaiting;
    int sent = 0;
    bit idling = 1'b1;
    bit hold_done = 1'b0;

    always #5 clk = ~clk;

    rgb_to_hsv i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    rgb_to_hsv_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .awaiting      (awaiting)
    );

    // offer one pixel, with an occasional gap before it
    task automatic send_pixel(input logic [CB-1:0] r, input logic [CB-1:0] g,
                              input logic [CB-1:0] b);
        int gap;
        if (idling && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 3);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata  <= rth_pkg::IN_TDATA_BITS'({b, g, r});
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        sent++;
    endtask

    // channel level biased toward the ends of the range
    function automatic logic [CB-1:0] pick_level();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return CB'($urandom_range(0, 3));
            3:       return ~CB'($urandom_range(0, 3));
            default: return CB'($urandom());
        endcase
    endfunction

    // stimulus
    initial
    begin
        logic [CB-1:0] r;
        logic [CB-1:0] g;
        logic [CB-1:0] b;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // black, white and gray
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        // primaries and near neighbors
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd1, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd1);
        // red largest with green below blue wraps the turn, last one has green above blue
        send_pixel(8'd255, 8'd0, 8'd1);
        send_pixel(8'd255, 8'd0, 8'd254);
        send_pixel(8'd255, 8'd1, 8'd0);
        // ties for the largest channel
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd100, 8'd100, 8'd50);
        send_pixel(8'd100, 8'd50, 8'd100);
        // small ranges and mixed colors
        send_pixel(8'd255, 8'd254, 8'd0);
        send_pixel(8'd254, 8'd255, 8'd0);
        send_pixel(8'd200, 8'd100, 8'd150);
        send_pixel(8'd1, 8'd2, 8'd3);
        send_pixel(8'd3, 8'd2, 8'd1);
        send_pixel(8'd255, 8'd128, 8'd0);
        send_pixel(8'd0, 8'd128, 8'd255);

        // random pixels, idle phases alternating with busy ones, quiet tail
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            idling = (i < RANDOM_ITEMS - QUIET_TAIL) && ((i / 150) % 3 != 2);
            r = pick_level();
            g = pick_level();
            b = pick_level();
            case ($urandom_range(0, 9))
                0: g = r;
                1: b = r;
                2: b = g;
                3:
                begin
                    g = r;
                    b = r;
                end
                default: ;
            endcase
            send_pixel(r, g, b);
        end
        s_axis_tvalid <= 1'b0;

        while (awaiting != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && awaiting == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // output side: random stalls and one long hold-off
    initial
    begin
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        m_axis_tready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (!hold_done && sent >= HOLD_AT)
            begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else if (idling && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog
    initial
    begin
        #1000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ sim.f @@
sv/rth_pkg.sv
sv/rgb_to_hsv.sv
tb/rgb_to_hsv_checker.sv
tb/rgb_to_hsv_tb.sv
